// ===== hdl/rbpw_pkg.sv =====
package rbpw_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int CW = 11;
  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [CW-1:0] WIDTH_RESET = 11'd640;
  localparam logic [CW-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [CW-1:0] RADIUS_RESET = 11'd400;
  // radicand h*h*d: h < 1024 -> 20 bits, d < 2^22 -> 42 bits
  localparam int RW = 42;
  localparam int QW = RW / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_OWN_RD, S_OWN_WAIT, S_SQRT_X, S_DIV_X,
    S_SQRT_Y, S_DIV_Y, S_SRC_RD, S_SRC_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic write;
    logic own_rd;
    logic own_cap;
    logic sq_start;
    logic sel_y;
    logic dv_start;
    logic dv_cap;
    logic src_rd;
    logic src_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic rd;
    logic lens;
    logic busy;
  } stat_t;
endpackage

// ===== hdl/rbpw_ram.sv =====
module rbpw_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/rbpw_ctrl.sv =====
module rbpw_ctrl import rbpw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cm
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (st.bad) state_next = S_OUT;
        else if (st.rd) state_next = S_OWN_RD;
        else state_next = S_IDLE;
      end
      S_OWN_RD: state_next = S_OWN_WAIT;
      S_OWN_WAIT: state_next = st.lens ? S_SQRT_X : S_OUT;
      S_SQRT_X: if (!st.busy) state_next = S_DIV_X;
      S_DIV_X: if (!st.busy) state_next = S_SQRT_Y;
      S_SQRT_Y: if (!st.busy) state_next = S_DIV_Y;
      S_DIV_Y: if (!st.busy) state_next = S_SRC_RD;
      S_SRC_RD: state_next = S_SRC_WAIT;
      S_SRC_WAIT: state_next = S_OUT;
      S_OUT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // start pulses fire on the first cycle of each unit state
  logic entered;
  state_t prev;
  always_ff @(posedge clk) begin
    if (rst) prev <= S_IDLE;
    else prev <= state;
  end
  assign entered = (prev != state);

  always_comb begin
    cm = '0;
    in_ready = (state == S_IDLE);
    cm.load = in_valid && (state == S_IDLE);
    case (state)
      S_CHECK: cm.write = !st.bad && !st.rd;
      S_OWN_RD: cm.own_rd = 1'b1;
      S_OWN_WAIT: cm.own_cap = 1'b1;
      S_SQRT_X: cm.sq_start = entered;
      S_DIV_X: begin cm.dv_start = entered; cm.dv_cap = !entered && !st.busy; end
      S_SQRT_Y: begin cm.sq_start = entered; cm.sel_y = 1'b1; end
      S_DIV_Y: begin
        cm.dv_start = entered; cm.sel_y = 1'b1;
        cm.dv_cap = !entered && !st.busy;
      end
      S_SRC_RD: cm.src_rd = 1'b1;
      S_SRC_WAIT: cm.src_cap = 1'b1;
      S_OUT: cm.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cm.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cm.load |-> state == S_IDLE) else $error("load outside idle");
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    cm.write |-> !st.bad) else $error("write on bad coord");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

// ===== hdl/rbpw_dp.sv =====
module rbpw_dp import rbpw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cm,
  output stat_t         st,
  input  logic          cmd,
  input  logic [XW-1:0] x,
  input  logic [YW-1:0] y,
  input  logic [31:0]   pixel,
  input  logic [CW-1:0] frame_width,
  input  logic [CW-1:0] frame_height,
  input  logic [CW-1:0] lens_radius,
  output logic [31:0]   warped_pixel,
  output logic          inside_lens,
  output logic          bad_coord
);
  logic          rcmd;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic [31:0]   rpix;
  always_ff @(posedge clk) begin
    if (cm.load) begin rcmd <= cmd; rx <= x; ry <= y; rpix <= pixel; end
  end

  logic [CW-1:0] w, h;
  assign w = (frame_width > CW'(MaxWidth)) ? CW'(MaxWidth) : frame_width;
  assign h = (frame_height > CW'(MaxHeight)) ? CW'(MaxHeight) : frame_height;
  logic bad;
  assign bad = ({1'b0, rx} >= w) || ({1'b0, ry} >= h);

  logic signed [CW:0] cx, cy, tx, ty;
  assign cx = $signed({2'b0, w[CW-1:1]});
  assign cy = $signed({2'b0, h[CW-1:1]});
  assign tx = $signed({2'b0, rx}) - cx;
  assign ty = $signed({2'b0, ry}) - cy;

  logic [CW-1:0] ax, ay;
  assign ax = tx[CW] ? CW'(-tx) : tx[CW-1:0];
  assign ay = ty[CW] ? CW'(-ty) : ty[CW-1:0];

  // registered squared distance and radius; the lens test compares them
  logic [22:0] sq_dist, r2;
  always_ff @(posedge clk) begin
    if (cm.own_rd) begin
      sq_dist <= 23'(ax * ax) + 23'(ay * ay);
      r2 <= 23'(lens_radius * lens_radius);
    end
  end
  logic in_lens;
  assign in_lens = sq_dist < r2;

  // halved offset magnitude, truncating toward zero
  logic [CW-2:0] hm;
  assign hm = ay[CW-1:1];
  logic [19:0] hh;
  always_ff @(posedge clk) begin
    if (cm.own_cap) hh <= ax[CW-1:1] * ax[CW-1:1];
    else if (cm.dv_cap && !cm.sel_y) hh <= hm * hm;
  end

  // iterative square root, one result bit per cycle
  logic [RW-1:0] rad;
  logic [QW+1:0] rem;
  logic [QW-1:0] root;
  logic [5:0]    sq_cnt;
  logic          sq_busy;
  logic [QW+1:0] trial;
  assign trial = {rem[QW-1:0], rad[RW-1 -: 2]} - {root, 2'b01};
  always_ff @(posedge clk) begin
    if (rst) sq_busy <= 1'b0;
    else if (cm.sq_start) begin
      sq_busy <= 1'b1;
      sq_cnt <= 6'(QW);
      rad <= RW'(hh * 22'(sq_dist));
      rem <= '0;
      root <= '0;
    end else if (sq_busy) begin
      if (!trial[QW+1]) begin
        rem <= trial; root <= {root[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[QW-1:0], rad[RW-1 -: 2]}; root <= {root[QW-2:0], 1'b0};
      end
      rad <= {rad[RW-3:0], 2'b00};
      sq_cnt <= sq_cnt - 6'd1;
      if (sq_cnt == 6'd1) sq_busy <= 1'b0;
    end
  end

  // restoring divider by the half radius
  logic [CW-2:0] rr;
  assign rr = lens_radius[CW-1:1];
  logic [QW-1:0] quo;
  logic [CW-1:0] drem;
  logic [QW-1:0] dnum;
  logic [4:0]    dv_cnt;
  logic          dv_busy;
  logic [CW:0]   dtry;
  assign dtry = {drem, dnum[QW-1]} - {2'b0, rr};
  always_ff @(posedge clk) begin
    if (rst) dv_busy <= 1'b0;
    else if (cm.dv_start) begin
      dv_busy <= 1'b1; dv_cnt <= 5'(QW); dnum <= root; drem <= '0; quo <= '0;
    end else if (dv_busy) begin
      if (!dtry[CW]) begin drem <= dtry[CW-1:0]; quo <= {quo[QW-2:0], 1'b1}; end
      else begin drem <= {drem[CW-2:0], dnum[QW-1]}; quo <= {quo[QW-2:0], 1'b0}; end
      dnum <= {dnum[QW-2:0], 1'b0};
      dv_cnt <= dv_cnt - 5'd1;
      if (dv_cnt == 5'd1) dv_busy <= 1'b0;
    end
  end

  // scaled offset, sign from the halved offset, then clamp into the frame
  logic [QW-1:0] s;
  assign s = (rr == '0) ? '0 : quo;
  logic neg;
  assign neg = cm.sel_y ? (ty[CW] && ay[CW-1:1] != '0) : (tx[CW] && ax[CW-1:1] != '0);
  logic signed [QW+1:0] pos;
  logic [CW-1:0] lim;
  assign pos = (cm.sel_y ? (QW+2)'(cy) : (QW+2)'(cx))
             + (neg ? -$signed({2'b0, s}) : $signed({2'b0, s}));
  assign lim = cm.sel_y ? h : w;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [CW-1:0] cl;
  always_comb begin
    if (pos < 0) cl = '0;
    else if (pos > $signed((QW+2)'(lim) - 1)) cl = lim - CW'(1);
    else cl = pos[CW-1:0];
  end
  always_ff @(posedge clk) begin
    if (cm.dv_cap && !cm.sel_y) sx <= cl[XW-1:0];
    if (cm.dv_cap && cm.sel_y) sy <= cl[YW-1:0];
  end

  logic [AW-1:0] raddr;
  logic [31:0]   rdata, own;
  assign raddr = cm.src_rd ? {sy, sx} : {ry, rx};
  rbpw_ram #(.Width(32), .Depth(MaxWidth * MaxHeight)) u_ram (
    .clk(clk), .we(cm.write), .waddr({ry, rx}), .wdata(rpix),
    .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] res;
  always_ff @(posedge clk) begin
    if (cm.own_cap) begin own <= rdata; res <= rdata; end
    else if (cm.src_cap) res <= {rdata[31:8], own[7:0]};
  end

  logic rin;
  always_ff @(posedge clk) begin
    if (cm.own_cap) rin <= in_lens;
  end

  always_ff @(posedge clk) begin
    if (cm.out_load) begin
      warped_pixel <= bad ? 32'd0 : res;
      inside_lens <= !bad && rin;
      bad_coord <= bad;
    end
  end

  assign st.bad = bad;
  assign st.rd = rcmd;
  assign st.lens = in_lens;
  assign st.busy = sq_busy || dv_busy || cm.sq_start || cm.dv_start;

  a_units: assert property (@(posedge clk) disable iff (rst)
    !(sq_busy && dv_busy)) else $error("units overlap");
  a_sq_len: assert property (@(posedge clk) disable iff (rst)
    cm.sq_start |=> sq_busy) else $error("sqrt did not start");
  a_dv_len: assert property (@(posedge clk) disable iff (rst)
    cm.dv_start |=> dv_busy) else $error("divider did not start");
endmodule

// ===== hdl/radial_bulge_pixel_warp_top.sv =====
// radial bulge pixel warp
// input channel (in_valid/in_ready) carries cmd, x, y, pixel. cmd 0 stores
// pixel at (x,y) and gives no result; cmd 1 reads the warped pixel.
// output channel (out_valid/out_ready) carries warped_pixel, inside_lens and
// bad_coord. a coordinate outside the active frame gives one result with
// bad_coord set and nothing stored.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes frame_width,
// frame_height and lens_radius; always ready, write only when idle.
// one beat at a time. a read inside the lens runs two 21-step square roots
// and two 21-step divides, one after the other on shared units, plus two
// reads of the frame memory's registered read port.
// reset restores register defaults and empties the control; frame contents
// are undefined until written. a stalled receiver holds the result in the
// output register; the next beat is still taken and worked on, then the block
// waits with its result and takes nothing more until the held one is taken.
module radial_bulge_pixel_warp_top import rbpw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cmd,
  input  logic [XW-1:0] x,
  input  logic [YW-1:0] y,
  input  logic [31:0]   pixel,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   warped_pixel,
  output logic          inside_lens,
  output logic          bad_coord,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [CW-1:0] cfg_data
);
  logic [CW-1:0] frame_width, frame_height, lens_radius;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      lens_radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH: frame_width <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        REG_RADIUS: lens_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_t  cm;
  stat_t st;
  rbpw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cm(cm)
  );
  rbpw_dp u_dp (
    .clk(clk), .rst(rst), .cm(cm), .st(st), .cmd(cmd), .x(x), .y(y),
    .pixel(pixel), .frame_width(frame_width), .frame_height(frame_height),
    .lens_radius(lens_radius), .warped_pixel(warped_pixel),
    .inside_lens(inside_lens), .bad_coord(bad_coord)
  );
endmodule
